>>> rtl/multichannel_ema_deadband_filter_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the EMA deadband filter
// Concurrent checks sampled on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef MULTICHANNEL_EMA_DEADBAND_FILTER_DEFINES_SVH
`define MULTICHANNEL_EMA_DEADBAND_FILTER_DEFINES_SVH

// Same-cycle implication
`define MCEF_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define MCEF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/mcef_pkg.sv
// ----------------------------------------------------------------------------
// mcef_pkg
// Widths, register codes and types shared by the EMA deadband filter.
// ----------------------------------------------------------------------------
package mcef_pkg;

	localparam int CHANNELS   = 8;
	localparam int CH_W       = 3;
	localparam int SAMPLE_W   = 8;
	localparam int FRAC_BITS  = 8;
	localparam int VAL_W      = SAMPLE_W + FRAC_BITS;

	localparam int ALPHA_W    = 9;
	localparam int ALPHA_FRAC = 8;
	localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(1 << ALPHA_FRAC);
	localparam logic [ALPHA_W-1:0] ALPHA_RST = ALPHA_W'(64);

	localparam int THR_W      = 16;
	localparam logic [THR_W-1:0] THR_RST = THR_W'(256);

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ALPHA  = 1'b0,
		REG_THRESH = 1'b1
	} cfg_reg_t;

	// One channel entry of the state memory
	typedef struct packed {
		logic [VAL_W-1:0] smooth;
		logic [VAL_W-1:0] applied;
	} entry_t;

endpackage

>>> rtl/mcef_if.sv
// ----------------------------------------------------------------------------
// mcef_if
// Valid/ready channels for samples in and filter results out.
// ----------------------------------------------------------------------------
interface mcef_smp_if;
	import mcef_pkg::*;

	logic                valid;
	logic                ready;
	logic [CH_W-1:0]     channel;
	logic [SAMPLE_W-1:0] sample;

	modport source (output valid, output channel, output sample, input ready);
	modport sink   (input valid, input channel, input sample, output ready);
endinterface

interface mcef_res_if;
	import mcef_pkg::*;

	logic             valid;
	logic             ready;
	logic [CH_W-1:0]  out_channel;
	logic [VAL_W-1:0] smoothed;
	logic             changed;
	logic [VAL_W-1:0] applied_value;

	modport source (output valid, output out_channel, output smoothed, output changed,
		output applied_value, input ready);
	modport sink   (input valid, input out_channel, input smoothed, input changed,
		input applied_value, output ready);
endinterface

>>> rtl/multichannel_ema_deadband_filter.sv
// ----------------------------------------------------------------------------
// multichannel_ema_deadband_filter
// Per-channel exponential moving average with a deadband change report.
// ----------------------------------------------------------------------------
// Usage:
//   smp carries one 8-bit sample tagged with a channel; res returns one result
//   per sample: channel, smoothed value (Q8.8), change flag and the applied
//   value. A transaction completes on a clock edge with valid and ready high.
//   A sample is registered into stage 1, then stage 2, then the output
//   register, which drives res.valid. While res is not stalled, one
//   sample is taken every cycle, also on the same channel back to back: the
//   smoothed value recurrence (subtract, multiply, shift, add) closes in one
//   stage, and later stages forward their results to earlier ones.
//   Smoothed and applied values sit in an 8-entry memory read into stage 1
//   at the transaction; seen flags are flip-flops.
//   Reset clears the seen flags, the pipeline valids and restores alpha to 64
//   and the threshold to 256; no clearing pass is needed, the first sample on
//   a channel loads its entry. While res is stalled the whole pipeline holds
//   and smp.ready drops; the output register still frees a slot per cycle as
//   soon as res.ready returns. Write configuration only while idle.
// ----------------------------------------------------------------------------
`include "multichannel_ema_deadband_filter_defines.svh"

module multichannel_ema_deadband_filter (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [mcef_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [mcef_pkg::CFG_DATA_W-1:0] cfg_wdata,
	mcef_smp_if.sink                        smp,
	mcef_res_if.source                      res
);
	import mcef_pkg::*;

	localparam int DIFF_W = VAL_W + 1;
	localparam int PROD_W = DIFF_W + ALPHA_W + 1;

	// Configuration
	logic [ALPHA_W-1:0] alpha_q;
	logic [THR_W-1:0]   thr_q;

	// Pipeline control
	logic adv;
	logic accept;
	logic wr_en;

	// State
	entry_t             mem_q [CHANNELS];
	logic [CHANNELS-1:0] seen_q;

	// Stage 1
	logic                s1_vld;
	logic [CH_W-1:0]     s1_ch;
	logic [VAL_W-1:0]    s1_target;
	logic                s1_first;
	entry_t              rd_s1;

	// Stage 2
	logic                s2_vld;
	logic [CH_W-1:0]     s2_ch;
	logic [VAL_W-1:0]    s2_smooth;
	logic [VAL_W-1:0]    s2_applied;
	logic                s2_first;

	// Output register, also the last write to the memory
	logic                out_vld_q;
	logic                wb_vld_q;
	logic [CH_W-1:0]     out_ch_q;
	logic [VAL_W-1:0]    out_smooth_q;
	logic                out_changed_q;
	logic [VAL_W-1:0]    out_applied_q;

	// Stage 1 datapath
	logic [VAL_W-1:0]         s1_smooth_old;
	logic [VAL_W-1:0]         s1_applied_old;
	logic signed [DIFF_W-1:0] s1_diff;
	logic signed [PROD_W-1:0] s1_prod;
	logic signed [PROD_W-1:0] s1_step;
	logic [VAL_W-1:0]         s1_smooth_new;

	// Stage 2 datapath
	logic [VAL_W-1:0] s2_applied_old;
	logic [VAL_W-1:0] s2_dist;
	logic             s2_hit;
	logic [VAL_W-1:0] s2_applied_new;

	logic [VAL_W-1:0] out_dist;

	// ------------------------------------------------------------------
	// Configuration registers; clamp alpha to one on write
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= ALPHA_RST;
			thr_q   <= THR_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_idx))
				REG_ALPHA: begin
					alpha_q <= (cfg_wdata[ALPHA_W-1:0] > ALPHA_ONE) ?
						ALPHA_ONE : cfg_wdata[ALPHA_W-1:0];
				end
				REG_THRESH: begin
					thr_q <= cfg_wdata[THR_W-1:0];
				end
				default: begin
					thr_q <= thr_q;
				end
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Handshake: every stage advances together whenever the output slot
	// is free or being emptied
	// ------------------------------------------------------------------
	assign adv       = !out_vld_q || res.ready;
	assign accept    = smp.valid && adv;
	assign wr_en     = s2_vld && adv;
	assign smp.ready = adv;

	// Seen flags: read and set at the transaction itself, so a following
	// sample on the same channel already sees the flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
		end else if (accept) begin
			seen_q[smp.channel] <= 1'b1;
		end
	end

	// ------------------------------------------------------------------
	// State memory: read at the transaction, written as stage 2 retires
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_s1 <= mem_q[smp.channel];
		end
		if (wr_en) begin
			mem_q[s2_ch] <= '{smooth: s2_smooth, applied: s2_applied_new};
		end
	end

	// ------------------------------------------------------------------
	// Stage 1 registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld <= 1'b0;
		end else if (adv) begin
			s1_vld <= smp.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s1_ch     <= smp.channel;
			s1_target <= {smp.sample, {FRAC_BITS{1'b0}}};
			s1_first  <= !seen_q[smp.channel];
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: forward the newest smoothed value (stage 2 first, then the
	// last write), then move it towards the target by alpha
	// ------------------------------------------------------------------
	always_comb begin
		if (s2_vld && (s2_ch == s1_ch)) begin
			s1_smooth_old = s2_smooth;
		end else if (wb_vld_q && (out_ch_q == s1_ch)) begin
			s1_smooth_old = out_smooth_q;
		end else begin
			s1_smooth_old = rd_s1.smooth;
		end

		// Applied value of stage 2 is not known yet; stage 2 patches it
		if (wb_vld_q && (out_ch_q == s1_ch)) begin
			s1_applied_old = out_applied_q;
		end else begin
			s1_applied_old = rd_s1.applied;
		end

		s1_diff = $signed({1'b0, s1_target}) - $signed({1'b0, s1_smooth_old});
		s1_prod = $signed({1'b0, alpha_q}) * s1_diff;
		// Arithmetic shift floors towards minus infinity
		s1_step = s1_prod >>> ALPHA_FRAC;

		if (s1_first) begin
			s1_smooth_new = s1_target;
		end else begin
			s1_smooth_new = s1_smooth_old + s1_step[VAL_W-1:0];
		end
	end

	// ------------------------------------------------------------------
	// Stage 2 registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_vld <= 1'b0;
		end else if (adv) begin
			s2_vld <= s1_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && s1_vld) begin
			s2_ch      <= s1_ch;
			s2_smooth  <= s1_smooth_new;
			s2_applied <= s1_applied_old;
			s2_first   <= s1_first;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: deadband test against the applied value
	// ------------------------------------------------------------------
	always_comb begin
		if (wb_vld_q && (out_ch_q == s2_ch)) begin
			s2_applied_old = out_applied_q;
		end else begin
			s2_applied_old = s2_applied;
		end

		s2_dist = (s2_smooth >= s2_applied_old) ? (s2_smooth - s2_applied_old) :
			(s2_applied_old - s2_smooth);
		s2_hit  = s2_first || (s2_dist >= thr_q);
		s2_applied_new = s2_hit ? s2_smooth : s2_applied_old;
	end

	// ------------------------------------------------------------------
	// Output register; its payload doubles as the last memory write
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			wb_vld_q  <= 1'b0;
		end else begin
			if (adv) begin
				out_vld_q <= s2_vld;
			end
			if (wr_en) begin
				wb_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			out_ch_q      <= s2_ch;
			out_smooth_q  <= s2_smooth;
			out_changed_q <= s2_hit;
			out_applied_q <= s2_applied_new;
		end
	end

	assign res.valid         = out_vld_q;
	assign res.out_channel   = out_ch_q;
	assign res.smoothed      = out_smooth_q;
	assign res.changed       = out_changed_q;
	assign res.applied_value = out_applied_q;

	assign out_dist = (out_smooth_q >= out_applied_q) ? (out_smooth_q - out_applied_q) :
		(out_applied_q - out_smooth_q);

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	`MCEF_ASSERT_IMPL(a_change_applies, out_vld_q && out_changed_q,
		out_smooth_q == out_applied_q, "reported change did not update the applied value")
	`MCEF_ASSERT_IMPL(a_deadband_holds, out_vld_q && !out_changed_q,
		out_dist < thr_q, "distance reached threshold without a change report")
	`MCEF_ASSERT_IMPL(a_s1_seen, s1_vld,
		seen_q[s1_ch], "sample in flight on a channel not marked seen")
	`MCEF_ASSERT_NEXT(a_seen_sticky, 1'b1,
		(seen_q & $past(seen_q)) == $past(seen_q), "seen flag cleared outside reset")

endmodule
